[rtl/core/murmur2_hash_stream_unit_assert.svh]
// ----------------------------------------------------------------------------
// MurmurHash2 stream unit assertion macros
// Shared concurrent assertion forms used by the hash engine.
// ----------------------------------------------------------------------------
`ifndef MURMUR2_HASH_STREAM_UNIT_ASSERT_SVH
`define MURMUR2_HASH_STREAM_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MHS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mhs_pkg.sv]
// ----------------------------------------------------------------------------
// MurmurHash2 stream package
// Constants, field widths and shared types of the hash stream unit.
// ----------------------------------------------------------------------------
package mhs_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NBYTES_W   = 3;
  localparam int unsigned IN_TDATA_W = 72;

  localparam logic [WORD_W-1:0] MIX_MULT   = 32'h5bd1_e995;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'd5381;
  localparam int unsigned KEY_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [NBYTES_W-1:0] NBYTES_FULL = 3'd4;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FULL,
    KIND_TAIL
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_A,
    ST_KEY_B,
    ST_HASH,
    ST_TAIL,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] seed;
    kind_t             kind;
    logic              first;
    logic              last;
  } entry_t;

endpackage

[rtl/core/mhs_front.sv]
// ----------------------------------------------------------------------------
// MurmurHash2 stream front end
// Holds the seed register, classifies each input word and masks tail bytes.
// ----------------------------------------------------------------------------
module mhs_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [mhs_pkg::WORD_W-1:0] cfg_wr_data,
  input  logic [mhs_pkg::WORD_W-1:0] data_word,
  input  logic [mhs_pkg::NBYTES_W-1:0] valid_bytes,
  input  logic                      first_item,
  input  logic                      last_item,
  input  logic [mhs_pkg::WORD_W-1:0] total_length,
  output mhs_pkg::entry_t           entry
);

  logic [mhs_pkg::WORD_W-1:0] seed_r;
  logic [mhs_pkg::WORD_W-1:0] seed_nxt;

  always_comb begin
    seed_nxt = cfg_wr_en ? cfg_wr_data : seed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= mhs_pkg::SEED_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  always_comb begin
    entry.seed  = seed_r ^ total_length;
    entry.first = first_item;
    entry.last  = last_item;
    entry.word  = data_word;
    if (valid_bytes >= mhs_pkg::NBYTES_FULL) begin
      entry.kind = mhs_pkg::KIND_FULL;
    end else if (valid_bytes == '0) begin
      entry.kind = mhs_pkg::KIND_NONE;
    end else begin
      entry.kind = mhs_pkg::KIND_TAIL;
      unique case (valid_bytes[1:0])
        2'd1:    entry.word = {24'd0, data_word[7:0]};
        2'd2:    entry.word = {16'd0, data_word[15:0]};
        default: entry.word = {8'd0, data_word[23:0]};
      endcase
    end
  end

endmodule

[rtl/core/mhs_queue.sv]
// ----------------------------------------------------------------------------
// MurmurHash2 stream queue
// Small FIFO of classified words between the front end and the hash engine.
// ----------------------------------------------------------------------------
module mhs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mhs_pkg::entry_t push_entry,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output mhs_pkg::entry_t head
);

  mhs_pkg::entry_t slot_r [mhs_pkg::QUEUE_DEPTH];

  logic [mhs_pkg::QUEUE_AW-1:0] wr_ptr_r;
  logic [mhs_pkg::QUEUE_AW-1:0] wr_ptr_nxt;
  logic [mhs_pkg::QUEUE_AW-1:0] rd_ptr_r;
  logic [mhs_pkg::QUEUE_AW-1:0] rd_ptr_nxt;
  logic [mhs_pkg::QUEUE_AW:0]   count_r;
  logic [mhs_pkg::QUEUE_AW:0]   count_nxt;

  assign push_ready = (count_r != (mhs_pkg::QUEUE_AW+1)'(mhs_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[rtl/core/mhs_back.sv]
// ----------------------------------------------------------------------------
// MurmurHash2 stream hash engine
// Mixes queued words with one shared multiplier and finalizes each message.
// ----------------------------------------------------------------------------
module mhs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  mhs_pkg::entry_t            head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mhs_pkg::WORD_W-1:0] out_hash,
  output logic                       out_err
);

  mhs_pkg::state_t state_r;
  mhs_pkg::state_t state_nxt;

  logic [mhs_pkg::WORD_W-1:0] h_r;
  logic [mhs_pkg::WORD_W-1:0] h_nxt;
  logic [mhs_pkg::WORD_W-1:0] k_r;
  logic [mhs_pkg::WORD_W-1:0] k_nxt;
  logic                       last_r;
  logic                       last_nxt;
  logic                       ps_r;
  logic                       ps_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [mhs_pkg::WORD_W-1:0] out_hash_r;
  logic [mhs_pkg::WORD_W-1:0] out_hash_nxt;
  logic                       out_err_r;
  logic                       out_err_nxt;

  logic [mhs_pkg::WORD_W-1:0]   mul_a;
  logic [2*mhs_pkg::WORD_W-1:0] mul_full;
  logic [mhs_pkg::WORD_W-1:0]   mul_p;

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;
  assign out_err   = out_err_r;

  always_comb begin
    unique case (state_r)
      mhs_pkg::ST_KEY_B: mul_a = k_r ^ (k_r >> mhs_pkg::KEY_SHIFT);
      mhs_pkg::ST_TAIL:  mul_a = h_r ^ k_r;
      mhs_pkg::ST_FIN:   mul_a = h_r ^ (h_r >> mhs_pkg::FIN_SHIFT_A);
      mhs_pkg::ST_KEY_A: mul_a = k_r;
      default:           mul_a = h_r;
    endcase
    mul_full = (2*mhs_pkg::WORD_W)'(mul_a) * (2*mhs_pkg::WORD_W)'(mhs_pkg::MIX_MULT);
    mul_p    = mul_full[mhs_pkg::WORD_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    ps_nxt        = ps_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_hash_nxt  = out_hash_r;
    out_err_nxt   = out_err_r;
    unique case (state_r)
      mhs_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          h_nxt    = head.first ? head.seed : h_r;
          k_nxt    = head.word;
          last_nxt = head.last;
          ps_nxt   = (head.first ? 1'b0 : ps_r) |
                     ((head.kind == mhs_pkg::KIND_TAIL) & ~head.last);
          unique case (head.kind)
            mhs_pkg::KIND_FULL: state_nxt = mhs_pkg::ST_KEY_A;
            mhs_pkg::KIND_TAIL: state_nxt = mhs_pkg::ST_TAIL;
            default:            state_nxt = head.last ? mhs_pkg::ST_FIN : mhs_pkg::ST_IDLE;
          endcase
        end
      end
      mhs_pkg::ST_KEY_A: begin
        k_nxt     = mul_p;
        state_nxt = mhs_pkg::ST_KEY_B;
      end
      mhs_pkg::ST_KEY_B: begin
        k_nxt     = mul_p;
        state_nxt = mhs_pkg::ST_HASH;
      end
      mhs_pkg::ST_HASH: begin
        h_nxt     = mul_p ^ k_r;
        state_nxt = last_r ? mhs_pkg::ST_FIN : mhs_pkg::ST_IDLE;
      end
      mhs_pkg::ST_TAIL: begin
        h_nxt     = mul_p;
        state_nxt = last_r ? mhs_pkg::ST_FIN : mhs_pkg::ST_IDLE;
      end
      mhs_pkg::ST_FIN: begin
        k_nxt     = mul_p;
        state_nxt = mhs_pkg::ST_OUT;
      end
      mhs_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = k_r ^ (k_r >> mhs_pkg::FIN_SHIFT_B);
          out_err_nxt   = ps_r;
          state_nxt     = mhs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mhs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhs_pkg::ST_IDLE;
      h_r         <= '0;
      ps_r        <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      ps_r        <= ps_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    out_hash_r <= out_hash_nxt;
    out_err_r  <= out_err_nxt;
  end

`include "murmur2_hash_stream_unit_assert.svh"

  `MHS_ASSERT_NEXT(a_key_seq, state_r == mhs_pkg::ST_KEY_A, state_r == mhs_pkg::ST_KEY_B, "key mix out of sequence")
  `MHS_ASSERT_NEXT(a_fin_seq, state_r == mhs_pkg::ST_FIN, state_r == mhs_pkg::ST_OUT, "finalize not followed by output")
  `MHS_ASSERT_NEXT(a_out_load, (state_r == mhs_pkg::ST_OUT) && (!out_valid_r || out_ready), out_valid_r, "result not loaded")
  `MHS_ASSERT_NEXT(a_seed_load, q_pop && head.first, h_r == $past(head.seed), "hash not seeded on first word")

endmodule

[rtl/core/murmur2_hash_stream_unit.sv]
// ----------------------------------------------------------------------------
// MurmurHash2 stream unit
// Streaming 32-bit MurmurHash2 over little-endian words, one hash per message.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_*     slave      tdata: data_word, valid_bytes, total_length; tuser: first; tlast: last
//  out_*    master     tdata: hash_value; tuser: framing_error
//  cfg_*    write      hash_seed
//
// A full word steps through KEY_A, KEY_B and HASH, a tail word through TAIL, and a word with no
// bytes stays in IDLE; a last word adds FIN and OUT. The single shared multiplier sets these steps.
// Reset clears the running hash and the error flag and loads the seed with 5381.
// A two-entry queue lets input continue while the engine works or the output stalls.
module murmur2_hash_stream_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mhs_pkg::WORD_W-1:0]     cfg_wr_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // data_word [31:0], valid_bytes [34:32], total_length [66:35], zero pad above.
  input  logic [mhs_pkg::IN_TDATA_W-1:0] in_tdata,
  // first_item.
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // hash_value [31:0].
  output logic [mhs_pkg::WORD_W-1:0]     out_tdata,
  // framing_error.
  output logic                           out_tuser
);

  mhs_pkg::entry_t fe_entry;
  mhs_pkg::entry_t q_head;
  logic            q_ready;
  logic            q_valid;
  logic            q_pop;

  assign in_tready = q_ready;

  mhs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .data_word    (in_tdata[31:0]),
    .valid_bytes  (in_tdata[34:32]),
    .first_item   (in_tuser),
    .last_item    (in_tlast),
    .total_length (in_tdata[66:35]),
    .entry        (fe_entry)
  );

  mhs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid & q_ready),
    .push_entry (fe_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .head       (q_head)
  );

  mhs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_hash  (out_tdata),
    .out_err   (out_tuser)
  );

endmodule

[tb/sv/murmur2_hash_stream_unit_test.sv]
// ----------------------------------------------------------------------------
// MurmurHash2 stream unit testbench
// Feeds directed and random word streams under several seeds, with random
// gaps and output stalls, and checks every hash against a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module murmur2_hash_stream_unit_test;

  localparam logic [31:0] MIX_K      = 32'h5bd1_e995;
  localparam logic [31:0] SEED_INIT  = 32'd5381;
  localparam int unsigned ITEM_GOAL  = 1450;
  localparam int unsigned QUIET_TAIL = 150;
  localparam int unsigned SETTLE_CYC = 30;
  localparam int unsigned STALL_MAX  = 2000;
  localparam int unsigned PAD_W      = mhs_pkg::IN_TDATA_W - 67;

  typedef struct packed {
    logic [31:0] hash;
    logic        ferr;
  } hash_res_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    bit          first;
    bit          last;
    logic [31:0] total;
    bit          typed;
    hash_res_t   typed_res;
  } word_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [mhs_pkg::WORD_W-1:0]     cfg_wr_data = '0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [mhs_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [mhs_pkg::WORD_W-1:0]     out_tdata;
  logic                           out_tuser;

  logic [31:0] seed_reg;
  logic [31:0] run_hash;
  bit          partial_flag;

  hash_res_t   hash_q[$];
  word_row_t   dir_tab[$];
  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 1'b0;

  murmur2_hash_stream_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction

  function automatic logic [31:0] finalize_hash(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in ^ (h_in >> 13);
    h = mul32(h, MIX_K);
    h = h ^ (h >> 15);
    return h;
  endfunction

  function automatic void murmur_step(input logic [31:0] word, input logic [2:0] nb_in,
                                      input bit first, input bit last,
                                      input logic [31:0] total, output bit has_res,
                                      output hash_res_t res);
    logic [31:0] h;
    logic [31:0] k;
    logic [31:0] mask;
    int unsigned nb;
    nb = (nb_in > 3'd4) ? 4 : int'(nb_in);
    if (first) begin
      h = seed_reg ^ total;
      partial_flag = 1'b0;
    end else begin
      h = run_hash;
    end
    if (nb == 4) begin
      k = mul32(word, MIX_K);
      k = k ^ (k >> 24);
      k = mul32(k, MIX_K);
      h = mul32(h, MIX_K) ^ k;
    end else if (nb > 0) begin
      mask = 32'hffff_ffff >> (8 * (4 - nb));
      h = mul32(h ^ (word & mask), MIX_K);
      if (!last) begin
        partial_flag = 1'b1;
      end
    end
    run_hash = h;
    has_res = last;
    res.hash = finalize_hash(h);
    res.ferr = partial_flag;
  endfunction

  // Called and returns at a falling edge; the data stays on the bus until the next call.
  task automatic send_word(input logic [31:0] word, input logic [2:0] nb, input bit first,
                           input bit last, input logic [31:0] total, input bit typed,
                           input hash_res_t typed_res);
    bit        has_res;
    hash_res_t pred;
    no_idle = (words_sent + QUIET_TAIL >= ITEM_GOAL);
    if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {{PAD_W{1'b0}}, total, nb, word};
    in_tuser = first;
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    murmur_step(word, nb, first, last, total, has_res, pred);
    if (has_res) begin
      hash_q.push_back(typed ? typed_res : pred);
    end
    words_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (hash_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    seed_reg = value;
  endtask

  task automatic send_message();
    int unsigned len;
    int unsigned n_words;
    int unsigned bad_pos;
    int unsigned pick;
    logic [31:0] total;
    logic [2:0]  nb;
    hash_res_t   none;
    none = '0;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(0, 16);
      end else if (pick < 95) begin
        len = $urandom_range(17, 64);
      end else begin
        len = $urandom_range(65, 400);
      end
      total = ($urandom_range(0, 9) == 0) ? $urandom : len;
      n_words = (len == 0) ? 1 : (len + 3) / 4;
      bad_pos = ($urandom_range(0, 19) == 0 && n_words > 1) ?
                $urandom_range(0, n_words - 2) : n_words;
      for (int unsigned i = 0; i < n_words; i++) begin
        if (i == n_words - 1) begin
          nb = (len == 0) ? 3'd0 : ((len % 4 == 0) ? 3'd4 : 3'(len % 4));
        end else if (i == bad_pos) begin
          nb = 3'($urandom_range(0, 3));
        end else begin
          nb = 3'd4;
        end
        if (nb == 3'd4 && $urandom_range(0, 9) == 0) begin
          nb = 3'($urandom_range(5, 7));
        end
        send_word($urandom, nb, i == 0, i == n_words - 1, total, 1'b0, none);
      end
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_word($urandom, 3'($urandom_range(0, 7)), $urandom_range(0, 1),
                  $urandom_range(0, 1), $urandom, 1'b0, none);
      end
    end
  endtask

  always @(negedge clk) begin
    if (!no_idle && stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 7);
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    hash_res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (hash_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual hash %h ferr %b",
                 $time, out_tdata, out_tuser);
        error_count++;
      end else begin
        exp_res = hash_q.pop_front();
        if (out_tdata !== exp_res.hash) begin
          $display("%0t: hash mismatch, expected %h, actual %h",
                   $time, exp_res.hash, out_tdata);
          error_count++;
        end
        if (out_tuser !== exp_res.ferr) begin
          $display("%0t: framing error mismatch, expected %b, actual %b",
                   $time, exp_res.ferr, out_tuser);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] phase_seed[5];
    int unsigned phase_gap[5];
    int unsigned phase_stall[5];
    int unsigned phase_end;
    int unsigned dir_words;
    seed_reg = SEED_INIT;
    run_hash = '0;
    partial_flag = 1'b0;
    phase_seed = '{32'h0000_0000, 32'hffff_ffff, $urandom, SEED_INIT, $urandom};
    phase_gap = '{30, 0, 50, 15, 25};
    phase_stall = '{30, 50, 0, 15, 25};

    // Rows with a typed result all reduce to a zero running hash.
    dir_tab = '{
      '{32'h0000_0000, 3'd0, 1, 1, 32'd5381,      1, '{32'h0, 1'b0}},
      '{32'hffff_ffff, 3'd0, 0, 1, 32'd0,         1, '{32'h0, 1'b0}},
      '{32'h0000_0000, 3'd4, 0, 1, 32'd0,         1, '{32'h0, 1'b0}},
      '{32'h0000_0000, 3'd0, 1, 1, 32'd0,         0, '{32'h0, 1'b0}},
      '{32'h0000_0000, 3'd0, 1, 1, 32'hffff_ffff, 0, '{32'h0, 1'b0}},
      '{32'hffff_ffff, 3'd4, 1, 1, 32'd4,         0, '{32'h0, 1'b0}},
      '{32'h0000_0000, 3'd4, 1, 1, 32'd4,         0, '{32'h0, 1'b0}},
      '{32'hffff_ffff, 3'd1, 1, 1, 32'd1,         0, '{32'h0, 1'b0}},
      '{32'ha5a5_a5a5, 3'd2, 1, 1, 32'd2,         0, '{32'h0, 1'b0}},
      '{32'hffff_ffff, 3'd3, 1, 1, 32'd3,         0, '{32'h0, 1'b0}},
      '{32'h0302_0100, 3'd4, 1, 0, 32'd11,        0, '{32'h0, 1'b0}},
      '{32'h0706_0504, 3'd4, 0, 0, 32'd0,         0, '{32'h0, 1'b0}},
      '{32'hff0a_0908, 3'd3, 0, 1, 32'd0,         0, '{32'h0, 1'b0}},
      '{32'hdead_beef, 3'd5, 1, 1, 32'd4,         0, '{32'h0, 1'b0}},
      '{32'hdead_beef, 3'd7, 1, 1, 32'd4,         0, '{32'h0, 1'b0}},
      '{32'h1234_5678, 3'd2, 1, 0, 32'd6,         0, '{32'h0, 1'b0}},
      '{32'h9abc_def0, 3'd4, 0, 1, 32'd0,         0, '{32'h0, 1'b0}},
      '{32'h8000_0001, 3'd4, 1, 0, 32'd8,         0, '{32'h0, 1'b0}},
      '{32'hffff_ffff, 3'd0, 0, 0, 32'd0,         0, '{32'h0, 1'b0}},
      '{32'h7fff_fffe, 3'd4, 0, 1, 32'd0,         0, '{32'h0, 1'b0}},
      '{32'h5555_aaaa, 3'd4, 1, 1, 32'h1234_5678, 0, '{32'h0, 1'b0}},
      '{32'h0000_00ff, 3'd1, 1, 0, 32'd5,         0, '{32'h0, 1'b0}},
      '{32'hcafe_f00d, 3'd4, 1, 1, 32'd4,         0, '{32'h0, 1'b0}}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    gap_pct = 20;
    stall_pct = 20;
    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].word, dir_tab[i].nbytes, dir_tab[i].first, dir_tab[i].last,
                dir_tab[i].total, dir_tab[i].typed, dir_tab[i].typed_res);
    end
    dir_words = words_sent;

    for (int p = 0; p < 5; p++) begin
      settle();
      write_seed(phase_seed[p]);
      gap_pct = phase_gap[p];
      stall_pct = phase_stall[p];
      phase_end = dir_words + (p + 1) * (ITEM_GOAL - dir_words) / 5;
      while (words_sent < phase_end) begin
        send_message();
      end
    end

    settle();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
